FILE: sv/mptw_pkg.sv
`timescale 1ns / 1ps

package mptw_pkg;

   localparam int unsigned MPTW_NUM_ENTRIES = 16;

   localparam logic [1:0] OP_READ        = 2'd0;
   localparam logic [1:0] OP_WRITE       = 2'd1;
   localparam logic [1:0] OP_SET_LOCATOR = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_BAD      = 2'd2;

   localparam logic [15:0] FIXED_OFFSET     = 16'h2000;
   localparam logic [31:0] FIXED_RESET      = 32'h8000_0C12;
   localparam logic [31:0] FIXED_READ_MASK  = 32'hFFFF_FFFB;
   localparam logic [31:0] FIXED_WRITE_MASK = 32'h0000_0DE4;
   localparam logic [11:0] BLOCKED_LOC      = 12'h800;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] offset;
      logic [31:0] write_data;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic disabled;
      logic blocked;
   } win_type;

endpackage

FILE: sv/mptw_window.sv
`timescale 1ns / 1ps

module mptw_window
   import mptw_pkg::*;
(
   input  logic [31:0] locator,
   input  logic [15:0] offset,
   output win_type     result
);

   logic [11:0] loc;
   logic [2:0]  span_exp;
   logic [12:0] loc_end;
   logic [16:0] lo_bound;
   logic [16:0] hi_bound;
   logic [16:0] off_ext;

   assign loc      = locator[11:0];
   assign span_exp = locator[26:24];
   assign loc_end  = {1'b0, loc} + (13'd1 << span_exp);
   assign lo_bound = {3'b000, loc, 2'b00};
   assign hi_bound = {2'b00, loc_end, 2'b00};
   assign off_ext  = {1'b0, offset};

   assign result.hit      = (off_ext >= lo_bound) && (off_ext < hi_bound);
   assign result.disabled = locator[31];
   assign result.blocked  = (loc == BLOCKED_LOC);

endmodule

FILE: sv/movable_page_table_window_regs.sv
`timescale 1ns / 1ps

// Register block of a movable first-level page table with NUM_ENTRIES windowed entries and one
// fixed map entry at offset 0x2000. Each item is captured in an input register, decoded and
// executed against all entry windows in parallel; its one result goes to an output register,
// a step that waits while that register holds a result not yet taken. A new item can be taken
// in every cycle while the output is not stalled. The entry comparators with their first-match
// priority pick lie between the registers. State updates of one item are seen by the next.
module movable_page_table_window_regs
   import mptw_pkg::*;
#(
   parameter int unsigned NUM_ENTRIES = MPTW_NUM_ENTRIES
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   logic        in_valid_ff;
   req_type     in_item_ff;
   logic        out_valid_ff;
   rsp_type     out_item_ff;
   logic [31:0] loc_ff  [NUM_ENTRIES];
   logic [31:0] val_ff  [NUM_ENTRIES];
   logic [15:0] base_ff [NUM_ENTRIES];
   logic [31:0] fixed_ff;

   win_type     win [NUM_ENTRIES];
   logic        advance;
   logic        is_fixed;
   logic        rd_found;
   logic [IDX_W-1:0] rd_sel;
   logic        wr_found;
   logic        wr_blocked;
   logic [IDX_W-1:0] wr_sel;
   logic [15:0] diff;
   logic [11:0] page;
   logic        idx_ok;
   logic        do_entry_write;
   rsp_type     out_item_in;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_win
      mptw_window u_window (
         .locator (loc_ff[g]),
         .offset  (in_item_ff.offset),
         .result  (win[g])
      );
   end

   always_comb begin
      rd_found   = 1'b0;
      rd_sel     = '0;
      wr_found   = 1'b0;
      wr_blocked = 1'b0;
      wr_sel     = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (!rd_found && win[i].hit) begin
            rd_found = 1'b1;
            rd_sel   = IDX_W'(i);
         end
         if (!wr_found && (win[i].blocked || win[i].hit)) begin
            wr_found   = 1'b1;
            wr_blocked = win[i].blocked;
            wr_sel     = IDX_W'(i);
         end
      end
   end

   assign is_fixed = (in_item_ff.offset == FIXED_OFFSET);
   assign diff     = in_item_ff.offset - base_ff[rd_sel];
   assign page     = in_item_ff.offset[13:2] - loc_ff[rd_sel][11:0] - diff[13:2];
   assign idx_ok   = ({1'b0, in_item_ff.entry_index} < 5'(NUM_ENTRIES));
   assign do_entry_write = (in_item_ff.op == OP_WRITE) && !is_fixed && wr_found &&
                           !wr_blocked && !win[wr_sel].disabled;

   always_comb begin
      out_item_in.read_data = '0;
      out_item_in.status    = STATUS_OK;
      case (in_item_ff.op)
         OP_READ: begin
            if (is_fixed) begin
               out_item_in.read_data = fixed_ff & FIXED_READ_MASK;
            end else if (!rd_found) begin
               out_item_in.status = STATUS_BAD;
            end else if (win[rd_sel].disabled) begin
               out_item_in.status = STATUS_DISABLED;
            end else begin
               out_item_in.read_data = val_ff[rd_sel] + {page, 20'd0};
            end
         end
         OP_WRITE: begin
            if (!is_fixed) begin
               if (!wr_found || wr_blocked) begin
                  out_item_in.status = STATUS_BAD;
               end else if (win[wr_sel].disabled) begin
                  out_item_in.status = STATUS_DISABLED;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fixed_ff     <= FIXED_RESET;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            loc_ff[i]  <= '0;
            val_ff[i]  <= '0;
            base_ff[i] <= '0;
         end
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_item_ff  <= req_item;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            out_item_ff  <= out_item_in;
            if (in_item_ff.op == OP_WRITE && is_fixed) begin
               fixed_ff <= fixed_ff | (in_item_ff.write_data & FIXED_WRITE_MASK);
            end
            if (do_entry_write) begin
               if (in_item_ff.write_data == 32'd0) begin
                  val_ff[wr_sel] <= '0;
                  loc_ff[wr_sel] <= 32'(wr_sel);
               end else begin
                  val_ff[wr_sel]  <= in_item_ff.write_data;
                  base_ff[wr_sel] <= in_item_ff.offset;
               end
            end
            if (in_item_ff.op == OP_SET_LOCATOR && idx_ok) begin
               loc_ff[in_item_ff.entry_index[IDX_W-1:0]] <= in_item_ff.write_data;
            end
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: tb/tb_movable_page_table_window_regs.sv
`timescale 1ns / 1ps

module tb_movable_page_table_window_regs;
   import mptw_pkg::*;

   localparam int unsigned NUM = MPTW_NUM_ENTRIES;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   logic [31:0] locator_q [NUM];
   logic [31:0] value_q [NUM];
   logic [15:0] base_q [NUM];
   logic [31:0] fixed_q;

   rsp_type expected_rsp_q [$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_len = 0;
   int hold_req_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;

   movable_page_table_window_regs dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit window_hit(input logic [31:0] w, input logic [15:0] off);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = {20'd0, w[11:0]} << 2;
      hi = ({20'd0, w[11:0]} + (32'd1 << w[26:24])) << 2;
      return ({16'd0, off} >= lo) && ({16'd0, off} < hi);
   endfunction

   // Works out the result of one access and applies its effect on the register state.
   function automatic rsp_type predict_access(input req_type it);
      rsp_type     r;
      logic [31:0] w;
      logic [31:0] a;
      logic [31:0] d;
      logic [31:0] pg;
      bit          done;
      r = '0;
      done = 1'b0;
      case (it.op)
         OP_READ: begin
            if (it.offset == FIXED_OFFSET) begin
               r.read_data = fixed_q & FIXED_READ_MASK;
            end else begin
               r.status = STATUS_BAD;
               for (int i = 0; i < NUM; i++) begin
                  w = locator_q[i];
                  if (!done && window_hit(w, it.offset)) begin
                     done = 1'b1;
                     if (w[31]) begin
                        r.status = STATUS_DISABLED;
                     end else begin
                        a = {20'd0, it.offset[13:2]};
                        d = ({16'd0, it.offset} - {16'd0, base_q[i]}) >> 2;
                        pg = (a - {20'd0, w[11:0]} - d) & 32'h0000_0FFF;
                        r.read_data = value_q[i] + (pg << 20);
                        r.status = STATUS_OK;
                     end
                  end
               end
            end
         end
         OP_WRITE: begin
            if (it.offset == FIXED_OFFSET) begin
               fixed_q = fixed_q | (it.write_data & FIXED_WRITE_MASK);
            end else begin
               r.status = STATUS_BAD;
               for (int i = 0; i < NUM; i++) begin
                  w = locator_q[i];
                  if (!done) begin
                     if (w[11:0] == BLOCKED_LOC) begin
                        done = 1'b1;
                     end else if (window_hit(w, it.offset)) begin
                        done = 1'b1;
                        if (w[31]) begin
                           r.status = STATUS_DISABLED;
                        end else if (it.write_data == 32'd0) begin
                           value_q[i] = 32'd0;
                           locator_q[i] = 32'(i);
                           r.status = STATUS_OK;
                        end else begin
                           value_q[i] = it.write_data;
                           base_q[i] = it.offset;
                           r.status = STATUS_OK;
                        end
                     end
                  end
               end
            end
         end
         OP_SET_LOCATOR: begin
            if (it.entry_index < NUM) begin
               locator_q[it.entry_index] = it.write_data;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [15:0] off,
                                        input logic [31:0] data, input logic [3:0] idx);
      req_type it;
      it.op = op;
      it.offset = off;
      it.write_data = data;
      it.entry_index = idx;
      return it;
   endfunction

   // Mostly aims at the window of some entry, so that writes and reads land on live entries.
   function automatic req_type random_access();
      req_type     it;
      logic [31:0] w;
      int          pick;
      int          j;
      int          span_bytes;
      it.write_data = $urandom;
      it.entry_index = 4'($urandom_range(0, 15));
      it.offset = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         it.op = OP_SET_LOCATOR;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            it.write_data[11:0] = BLOCKED_LOC;
         end else if (pick < 85) begin
            it.write_data[11:0] = 12'($urandom_range(0, 63));
         end
         it.write_data[26:24] = 3'($urandom_range(0, 7));
         it.write_data[31] = ($urandom_range(0, 99) < 20);
      end else begin
         if (pick < 50) begin
            it.op = OP_WRITE;
         end else if (pick < 93) begin
            it.op = OP_READ;
         end else begin
            it.op = OP_UNUSED;
         end
         if ($urandom_range(0, 99) < 12) begin
            it.write_data = 32'd0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            j = $urandom_range(0, NUM - 1);
            w = locator_q[j];
            span_bytes = 4 << w[26:24];
            it.offset = 16'({w[11:0], 2'b00} + $urandom_range(0, span_bytes - 1));
         end else if (pick < 80) begin
            it.offset = FIXED_OFFSET;
         end
      end
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input req_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(predict_access(it));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_req_seq != hold_seen) begin
         hold_seen = hold_req_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected item: read_data %h, status %0d",
                   rsp_item.read_data, rsp_item.status);
            fail_count++;
         end else begin
            if (rsp_item.read_data !== expected_rsp_q[0].read_data) begin
               $error("read_data: expected %h, got %h",
                      expected_rsp_q[0].read_data, rsp_item.read_data);
               fail_count++;
            end
            if (rsp_item.status !== expected_rsp_q[0].status) begin
               $error("status: expected %0d, got %0d",
                      expected_rsp_q[0].status, rsp_item.status);
               fail_count++;
            end
            void'(expected_rsp_q.pop_front());
         end
      end
   end

   task automatic test_fixed_entry();
      send_item(make_req(OP_READ, FIXED_OFFSET, 32'd0, 4'd0));
      send_item(make_req(OP_WRITE, FIXED_OFFSET, 32'hFFFF_FFFF, 4'd15));
      send_item(make_req(OP_READ, FIXED_OFFSET, 32'hFFFF_FFFF, 4'd15));
      send_item(make_req(OP_WRITE, FIXED_OFFSET, 32'd0, 4'd0));
   endtask

   task automatic test_window_basics();
      send_item(make_req(OP_READ, 16'h0000, 32'd0, 4'd0));
      send_item(make_req(OP_READ, 16'hFFFF, 32'd0, 4'd0));
      send_item(make_req(OP_WRITE, 16'h0000, 32'hFFFF_FFFF, 4'd0));
      send_item(make_req(OP_READ, 16'h0003, 32'd0, 4'd0));
      send_item(make_req(OP_WRITE, 16'hFFFE, 32'hA5A5_5A5A, 4'd0));
   endtask

   task automatic test_disabled_and_blocked();
      send_item(make_req(OP_SET_LOCATOR, 16'd0, 32'h8700_0010, 4'd3));
      send_item(make_req(OP_READ, 16'h0044, 32'd0, 4'd0));
      send_item(make_req(OP_WRITE, 16'h0044, 32'h0000_1234, 4'd0));
      send_item(make_req(OP_SET_LOCATOR, 16'd0, 32'h0300_0800, 4'd1));
      send_item(make_req(OP_WRITE, 16'h0044, 32'h0000_1234, 4'd0));
      send_item(make_req(OP_READ, 16'h2004, 32'd0, 4'd0));
      send_item(make_req(OP_WRITE, 16'h0000, 32'h0000_0005, 4'd0));
      send_item(make_req(OP_SET_LOCATOR, 16'd0, 32'd0, 4'd1));
   endtask

   task automatic test_zero_write_and_extremes();
      send_item(make_req(OP_WRITE, 16'h0000, 32'd0, 4'd0));
      send_item(make_req(OP_SET_LOCATOR, 16'd0, 32'h0700_0FFF, 4'd15));
      send_item(make_req(OP_WRITE, 16'h41F8, 32'h1234_5678, 4'd0));
      send_item(make_req(OP_READ, 16'h3FFC, 32'd0, 4'd0));
      send_item(make_req(OP_READ, 16'h41FC, 32'd0, 4'd0));
      send_item(make_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'd15));
   endtask

   task automatic test_random(input int n, input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_stall_pct = receiver_pct;
      repeat (n) send_item(random_access());
   endtask

   task automatic test_input_stall();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len = 300;
      hold_req_seq++;
      repeat (40) send_item(random_access());
   endtask

   task automatic test_sender_pause();
      send_idle_pct = 0;
      recv_stall_pct = 30;
      repeat (20) send_item(random_access());
      wait_drained();
      repeat (20) send_item(random_access());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      for (int i = 0; i < NUM; i++) begin
         locator_q[i] = 32'd0;
         value_q[i] = 32'd0;
         base_q[i] = 16'd0;
      end
      fixed_q = FIXED_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_fixed_entry();
      test_window_basics();
      test_disabled_and_blocked();
      test_zero_write_and_extremes();
      test_random(350, 0, 0);
      test_random(350, 55, 0);
      test_random(350, 0, 55);
      test_random(350, 17, 17);
      test_input_stall();
      test_sender_pause();

      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: movable_page_table_window_regs.f
sv/mptw_pkg.sv
sv/mptw_window.sv
sv/movable_page_table_window_regs.sv
tb/tb_movable_page_table_window_regs.sv
